// File: design/mdio_pkg.sv
// Package for the MDIO management master: item mode codes, command field
// codes, frame layout constants, the result beat type and the frame builder.
// Has no dependencies; used by mdio_master_regs.
package mdio_pkg;

    localparam int PREAMBLE_BITS = 32;
    localparam int PRE_LEN = (PREAMBLE_BITS > 32) ? 32 : PREAMBLE_BITS;
    localparam logic [6:0] FRAME_BITS = 7'(PRE_LEN + 32);
    localparam logic [6:0] RELEASE_BITS = 7'd18;
    localparam logic [6:0] DATA_BITS = 7'd16;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd21;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] GOC_WRITE = 2'd1;
    localparam logic [1:0] GOC_READ  = 2'd3;

    localparam logic [1:0] ST_C22 = 2'b01;
    localparam logic [1:0] ST_C45 = 2'b00;
    localparam logic [1:0] OP_ADDR = 2'b00;
    localparam logic [1:0] OP_WRITE = 2'b01;
    localparam logic [1:0] OP_C22_READ = 2'b10;
    localparam logic [1:0] OP_C45_READ = 2'b11;
    localparam logic [1:0] TA_WRITE = 2'b10;
    localparam logic [1:0] TA_READ = 2'b00;

    typedef struct packed {
        logic [4:0] pa;
        logic [4:0] rda;
        logic [1:0] goc;
        logic       c45;
        logic       busy;
    } cmd_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        mdc;
        logic        mdio_out;
        logic        mdio_drive;
        logic        busy_res;
    } mdio_res_t;

    function automatic logic [63:0] build_frame(
        input logic [1:0]  st,
        input logic [1:0]  op,
        input logic [4:0]  pa,
        input logic [4:0]  rda,
        input logic [1:0]  ta,
        input logic [15:0] data16
    );
        logic [31:0] word;
        logic [63:0] pre;
        word = {st, op, pa, rda, ta, data16};
        pre = ~64'd0 << (64 - PRE_LEN);
        return pre | ({32'd0, word} << (32 - PRE_LEN));
    endfunction

    function automatic logic [63:0] data_frame(
        input cmd_t        cmd,
        input logic [15:0] data16
    );
        logic [1:0] st;
        st = cmd.c45 ? ST_C45 : ST_C22;
        if (cmd.goc == GOC_READ)
        begin
            return build_frame(st, cmd.c45 ? OP_C45_READ : OP_C22_READ,
                               cmd.pa, cmd.rda, TA_READ, 16'd0);
        end
        return build_frame(st, OP_WRITE, cmd.pa, cmd.rda, TA_WRITE, data16);
    endfunction

endpackage

// File: design/mdio_master_regs.sv
// MDIO management master (Clause 22 and Clause 45) with command and data
// registers and a tick-driven MDC divider. Depends on mdio_pkg.
//
//   channel | signals                                       | direction
//   input   | in_valid, in_stall, mode, reg_select,         | beat in
//           | write_data, mdio_in                           |
//   output  | out_valid, out_stall, read_data, mdc,         | beat out
//           | mdio_out, mdio_drive, busy_res                |
//   config  | cfg_write_enable, cfg_write_data              | write only
//
// Each result beat is registered into the output register, or the skid
// register if stalled; one beat per cycle is sustained without stalls.
// A skid register holds one result while the output is stalled; in_stall
// rises only when that skid register is full.
// Reset clears all but the result data; half period resets to 21 ticks.
module mdio_master_regs
    import mdio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic        reg_select,
    input  logic [31:0] write_data,
    input  logic        mdio_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        mdc,
    output logic        mdio_out,
    output logic        mdio_drive,
    output logic        busy_res
);

    logic [7:0]  half_period_reg;
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] data_word_reg, data_word_next;
    logic [63:0] frame_shift_reg, frame_shift_next;
    logic [6:0]  bit_count_reg, bit_count_next;
    logic [7:0]  divide_count_reg, divide_count_next;
    logic        clock_level_reg, clock_level_next;
    logic        second_frame_reg, second_frame_next;

    mdio_res_t   out_reg, skid_reg, res_next;
    logic        out_valid_reg, skid_valid_reg;

    logic        accept;
    logic        out_fire;
    logic [7:0]  half_period;
    logic [7:0]  div_inc;
    logic [6:0]  bit_dec;
    logic        read_frame;
    logic        read_frame_next;
    logic        goc_valid;
    logic [31:0] rd;
    cmd_t        cmd_new;

    assign accept = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign half_period = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign div_inc = divide_count_reg + 8'd1;
    assign bit_dec = (bit_count_reg != 7'd0) ? bit_count_reg - 7'd1 : 7'd0;
    assign read_frame = (cmd_reg.goc == GOC_READ) && (!cmd_reg.c45 || second_frame_reg);
    assign goc_valid = (write_data[3:2] == GOC_WRITE) || (write_data[3:2] == GOC_READ);
    assign cmd_new = '{pa: write_data[25:21], rda: write_data[20:16],
                       goc: write_data[3:2], c45: write_data[1], busy: 1'b0};

    always_comb
    begin
        cmd_next = cmd_reg;
        data_word_next = data_word_reg;
        frame_shift_next = frame_shift_reg;
        bit_count_next = bit_count_reg;
        divide_count_next = divide_count_reg;
        clock_level_next = clock_level_reg;
        second_frame_next = second_frame_reg;
        rd = 32'd0;
        unique case (mode_t'(mode))
            MODE_WRITE:
            begin
                if (!cmd_reg.busy)
                begin
                    if (reg_select)
                    begin
                        data_word_next = write_data;
                    end
                    else
                    begin
                        cmd_next = cmd_new;
                        if (write_data[0] && goc_valid)
                        begin
                            cmd_next.busy = 1'b1;
                            divide_count_next = 8'd0;
                            clock_level_next = 1'b0;
                            second_frame_next = 1'b0;
                            bit_count_next = FRAME_BITS;
                            if (write_data[1])
                            begin
                                frame_shift_next = build_frame(ST_C45, OP_ADDR,
                                    cmd_new.pa, cmd_new.rda, TA_WRITE,
                                    data_word_reg[31:16]);
                            end
                            else
                            begin
                                frame_shift_next = data_frame(cmd_new, data_word_reg[15:0]);
                            end
                        end
                    end
                end
            end
            MODE_READ:
            begin
                if (reg_select)
                begin
                    rd = data_word_reg;
                end
                else
                begin
                    rd = {6'd0, cmd_reg.pa, cmd_reg.rda, 12'd0, cmd_reg.goc,
                          cmd_reg.c45, cmd_reg.busy};
                end
            end
            MODE_TICK:
            begin
                if (cmd_reg.busy)
                begin
                    if (div_inc < half_period)
                    begin
                        divide_count_next = div_inc;
                    end
                    else
                    begin
                        divide_count_next = 8'd0;
                        if (!clock_level_reg)
                        begin
                            clock_level_next = 1'b1;
                            if (read_frame && bit_count_reg >= 7'd1
                                && bit_count_reg <= DATA_BITS)
                            begin
                                data_word_next[15:0] = {data_word_reg[14:0], mdio_in};
                            end
                        end
                        else
                        begin
                            clock_level_next = 1'b0;
                            frame_shift_next = frame_shift_reg << 1;
                            bit_count_next = bit_dec;
                            if (bit_dec == 7'd0)
                            begin
                                if (cmd_reg.c45 && !second_frame_reg)
                                begin
                                    second_frame_next = 1'b1;
                                    frame_shift_next = data_frame(cmd_reg,
                                                                  data_word_reg[15:0]);
                                    bit_count_next = FRAME_BITS;
                                end
                                else
                                begin
                                    cmd_next.busy = 1'b0;
                                    frame_shift_next = 64'd0;
                                    bit_count_next = 7'd0;
                                    divide_count_next = 8'd0;
                                    clock_level_next = 1'b0;
                                    second_frame_next = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            MODE_NONE:
            begin
                rd = 32'd0;
            end
        endcase
    end

    assign read_frame_next = (cmd_next.goc == GOC_READ)
                             && (!cmd_next.c45 || second_frame_next);

    always_comb
    begin
        res_next.read_data = rd;
        res_next.busy_res = cmd_next.busy;
        res_next.mdc = cmd_next.busy && clock_level_next;
        res_next.mdio_drive = cmd_next.busy
                              && !(read_frame_next && bit_count_next <= RELEASE_BITS);
        res_next.mdio_out = res_next.mdio_drive && frame_shift_next[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            cmd_reg <= '0;
            data_word_reg <= 32'd0;
            frame_shift_reg <= 64'd0;
            bit_count_reg <= 7'd0;
            divide_count_reg <= 8'd0;
            clock_level_reg <= 1'b0;
            second_frame_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                half_period_reg <= cfg_write_data;
            end
            if (accept)
            begin
                cmd_reg <= cmd_next;
                data_word_reg <= data_word_next;
                frame_shift_reg <= frame_shift_next;
                bit_count_reg <= bit_count_next;
                divide_count_reg <= divide_count_next;
                clock_level_reg <= clock_level_next;
                second_frame_reg <= second_frame_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_reg.read_data;
    assign mdc = out_reg.mdc;
    assign mdio_out = out_reg.mdio_out;
    assign mdio_drive = out_reg.mdio_drive;
    assign busy_res = out_reg.busy_res;

endmodule

// File: sim/mdio_master_monitor.sv
// Monitor for the MDIO management master: watches the configuration port and both beat
// channels, predicts each result beat from its own model of the master and compares them.
// Depends on mdio_pkg for the mode and command field codes, the frame layout and types.
module mdio_master_monitor
    import mdio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  mode,
    input  logic        reg_select,
    input  logic [31:0] write_data,
    input  logic        mdio_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] read_data,
    input  logic        mdc,
    input  logic        mdio_out,
    input  logic        mdio_drive,
    input  logic        busy_res,
    output int          error_count,
    output int          pending
);

    logic [7:0]  half_period;
    cmd_t        cmd;
    logic [31:0] data_reg;
    logic [63:0] shifter;
    logic [6:0]  bits_left;
    logic [7:0]  div_cnt;
    logic        mdc_level;
    logic        second_frame;
    mdio_res_t   expected_pins[$];
    int          errors = 0;

    function automatic bit reading_now();
        return cmd.goc == GOC_READ && (!cmd.c45 || second_frame);
    endfunction

    task automatic load_shifter(input logic [1:0] st, input logic [1:0] op,
                                input logic [1:0] ta, input logic [15:0] d16);
        logic [31:0] word;
        word = {st, op, cmd.pa, cmd.rda, ta, d16};
        shifter = {32'd0, word} << (32 - PRE_LEN);
        if (PRE_LEN > 0)
        begin
            shifter = shifter | (~64'd0 << (64 - PRE_LEN));
        end
        bits_left = 7'(PRE_LEN + 32);
    endtask

    task automatic load_data_frame();
        logic [1:0] st;
        st = cmd.c45 ? ST_C45 : ST_C22;
        if (cmd.goc == GOC_READ)
        begin
            load_shifter(st, cmd.c45 ? OP_C45_READ : OP_C22_READ, TA_READ, 16'd0);
        end
        else
        begin
            load_shifter(st, OP_WRITE, TA_WRITE, data_reg[15:0]);
        end
    endtask

    task automatic go_idle();
        cmd.busy = 1'b0;
        shifter = '0;
        bits_left = '0;
        div_cnt = '0;
        mdc_level = 1'b0;
        second_frame = 1'b0;
    endtask

    task automatic clock_tick(input logic pin);
        logic [7:0] hp;
        hp = (half_period == 8'd0) ? 8'd1 : half_period;
        if (!cmd.busy)
        begin
            return;
        end
        div_cnt = div_cnt + 8'd1;
        if (div_cnt < hp)
        begin
            return;
        end
        div_cnt = '0;
        if (!mdc_level)
        begin
            mdc_level = 1'b1;
            if (reading_now() && bits_left >= 7'd1 && bits_left <= DATA_BITS)
            begin
                data_reg[15:0] = {data_reg[14:0], pin};
            end
            return;
        end
        mdc_level = 1'b0;
        shifter = shifter << 1;
        if (bits_left != 7'd0)
        begin
            bits_left = bits_left - 7'd1;
        end
        if (bits_left == 7'd0)
        begin
            if (cmd.c45 && !second_frame)
            begin
                second_frame = 1'b1;
                load_data_frame();
            end
            else
            begin
                go_idle();
            end
        end
    endtask

    task automatic advance_master(input logic [1:0] m, input logic sel,
                                  input logic [31:0] wd, input logic pin,
                                  output mdio_res_t res);
        logic drive;
        res = '0;
        case (m)
            MODE_WRITE:
            begin
                if (!cmd.busy && sel)
                begin
                    data_reg = wd;
                end
                else if (!cmd.busy)
                begin
                    cmd.pa = wd[25:21];
                    cmd.rda = wd[20:16];
                    cmd.goc = wd[3:2];
                    cmd.c45 = wd[1];
                    cmd.busy = 1'b0;
                    if (wd[0] && (cmd.goc == GOC_WRITE || cmd.goc == GOC_READ))
                    begin
                        cmd.busy = 1'b1;
                        div_cnt = '0;
                        mdc_level = 1'b0;
                        second_frame = 1'b0;
                        if (cmd.c45)
                        begin
                            load_shifter(ST_C45, OP_ADDR, TA_WRITE, data_reg[31:16]);
                        end
                        else
                        begin
                            load_data_frame();
                        end
                    end
                end
            end
            MODE_READ:
            begin
                res.read_data = sel ? data_reg
                                    : {6'd0, cmd.pa, cmd.rda, 12'd0, cmd.goc, cmd.c45, cmd.busy};
            end
            MODE_TICK:
            begin
                clock_tick(pin);
            end
            default:
            begin
            end
        endcase
        drive = cmd.busy && !(reading_now() && bits_left <= RELEASE_BITS);
        res.busy_res = cmd.busy;
        res.mdc = cmd.busy & mdc_level;
        res.mdio_drive = drive;
        res.mdio_out = drive & shifter[63];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        mdio_res_t want;
        if (!rst_n)
        begin
            half_period = HALF_PERIOD_RESET;
            cmd = '0;
            data_reg = '0;
            go_idle();
            expected_pins.delete();
            pending <= 0;
            error_count <= errors;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pins.size() == 0)
                begin
                    $error("result beat arrived with no beat expected");
                    errors++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("read_data", want.read_data, read_data);
                    check_field("mdc", 32'(want.mdc), 32'(mdc));
                    check_field("mdio_out", 32'(want.mdio_out), 32'(mdio_out));
                    check_field("mdio_drive", 32'(want.mdio_drive), 32'(mdio_drive));
                    check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
                end
            end
            if (cfg_write_enable)
            begin
                half_period = cfg_write_data;
            end
            if (in_valid && !in_stall)
            begin
                advance_master(mode, reg_select, write_data, mdio_in, want);
                expected_pins.push_back(want);
            end
            pending <= expected_pins.size();
            error_count <= errors;
        end
    end

endmodule

// File: sim/tb_top.sv
// Top of the MDIO management master testbench: clock, reset, configuration writes,
// beat stimulus with idling phases and the verdict. Depends on mdio_pkg,
// mdio_master_regs and mdio_master_monitor.
module tb_top;
    import mdio_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [7:0]  cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_NONE;
    logic        reg_select = 1'b0;
    logic [31:0] write_data = '0;
    logic        mdio_in = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    int          error_count;
    int          pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          half_ticks = HALF_PERIOD_RESET;

    always #10 clk = ~clk;

    mdio_master_regs DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .reg_select(reg_select),
        .write_data(write_data),
        .mdio_in(mdio_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .mdc(mdc),
        .mdio_out(mdio_out),
        .mdio_drive(mdio_drive),
        .busy_res(busy_res)
    );

    mdio_master_monitor u_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .reg_select(reg_select),
        .write_data(write_data),
        .mdio_in(mdio_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .mdc(mdc),
        .mdio_out(mdio_out),
        .mdio_drive(mdio_drive),
        .busy_res(busy_res),
        .error_count(error_count),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic put_beat(input logic [1:0] m, input logic sel, input logic [31:0] wd,
                            input logic pin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        reg_select <= sel;
        write_data <= wd;
        mdio_in <= pin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Ticks needed to finish the frames, with reads, ignored writes and no-ops mixed in.
    task automatic run_ticks(input int frames);
        int remaining;
        int pick;
        remaining = 2 * (half_ticks == 0 ? 1 : half_ticks) * int'(FRAME_BITS) * frames;
        while (remaining > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                put_beat(MODE_READ, 1'($urandom_range(1)), $urandom,
                         1'($urandom_range(1)));
            end
            else if (pick < 5)
            begin
                put_beat(MODE_WRITE, 1'($urandom_range(1)), $urandom,
                         1'($urandom_range(1)));
            end
            else if (pick < 6)
            begin
                put_beat(MODE_NONE, 1'($urandom_range(1)), $urandom,
                         1'($urandom_range(1)));
            end
            else
            begin
                put_beat(MODE_TICK, 1'($urandom_range(1)), $urandom,
                         1'($urandom_range(1)));
                remaining--;
            end
        end
    endtask

    task automatic random_transfer(input logic c45);
        logic [31:0] cmd_word;
        put_beat(MODE_WRITE, 1'b1, $urandom, 1'($urandom_range(1)));
        cmd_word = $urandom;
        cmd_word[3:2] = ($urandom_range(1) != 0) ? GOC_READ : GOC_WRITE;
        cmd_word[1] = c45;
        cmd_word[0] = 1'b1;
        put_beat(MODE_WRITE, 1'b0, cmd_word, 1'($urandom_range(1)));
        run_ticks(c45 ? 2 : 1);
        put_beat(MODE_READ, 1'b1, $urandom, 1'($urandom_range(1)));
        put_beat(MODE_READ, 1'b0, $urandom, 1'($urandom_range(1)));
    endtask

    // Command writes here never start a transfer.
    task automatic noise_beat();
        logic [1:0]  m;
        logic        sel;
        logic [31:0] wd;
        m = 2'($urandom_range(3));
        sel = 1'($urandom_range(1));
        wd = $urandom;
        if (m == MODE_WRITE && !sel && (wd[3:2] == GOC_READ || wd[3:2] == GOC_WRITE))
        begin
            wd[0] = 1'b0;
        end
        put_beat(m, sel, wd, 1'($urandom_range(1)));
    endtask

    task automatic set_half_period(input logic [7:0] value);
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        half_ticks = int'(value);
    endtask

    task automatic run_phase(input logic [7:0] hp, input int idle, input int stall,
                             input logic c45);
        set_half_period(hp);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (6) noise_beat();
        random_transfer(c45);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Idle register behavior and commands that must not start a transfer.
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);
        put_beat(MODE_READ, 1'b1, 32'hFFFF_FFFF, 1'b1);
        put_beat(MODE_TICK, 1'b0, 32'h0000_0000, 1'b1);
        put_beat(MODE_NONE, 1'b1, 32'hFFFF_FFFF, 1'b0);
        put_beat(MODE_WRITE, 1'b1, 32'hFFFF_FFFF, 1'b0);
        put_beat(MODE_WRITE, 1'b0, 32'hFFFF_FFF2, 1'b0);
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);
        put_beat(MODE_WRITE, 1'b0, 32'h0000_0009, 1'b0);
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);
        put_beat(MODE_WRITE, 1'b0, 32'h0000_0004, 1'b0);
        put_beat(MODE_WRITE, 1'b0, 32'h0000_0001, 1'b0);
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);

        // Clause 45 read with every address bit set, poked while busy.
        set_half_period(8'd0);
        send_idle_pct = 0;
        stall_pct = 0;
        put_beat(MODE_WRITE, 1'b0, 32'hFFFF_FFFF, 1'b0);
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);
        put_beat(MODE_READ, 1'b1, 32'h0000_0000, 1'b0);
        put_beat(MODE_WRITE, 1'b1, 32'h0000_0000, 1'b0);
        put_beat(MODE_WRITE, 1'b0, 32'h0000_0000, 1'b0);
        put_beat(MODE_NONE, 1'b0, 32'h0000_0000, 1'b1);
        run_ticks(2);
        put_beat(MODE_READ, 1'b1, 32'h0000_0000, 1'b0);
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);

        // Clause 22 write with all-zero addresses and data.
        set_half_period(8'd1);
        send_idle_pct = 60;
        stall_pct = 0;
        put_beat(MODE_WRITE, 1'b1, 32'h0000_0000, 1'b0);
        put_beat(MODE_WRITE, 1'b0, 32'h0000_0005, 1'b0);
        run_ticks(1);
        put_beat(MODE_READ, 1'b0, 32'h0000_0000, 1'b0);

        run_phase(8'd2, 0, 60, 1'b0);
        run_phase(8'd1, 11, 11, 1'b0);

        in_valid <= 1'b0;
        stall_pct = 0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
design/mdio_pkg.sv
design/mdio_master_regs.sv
sim/mdio_master_monitor.sv
sim/tb_top.sv
